/* hw/rtl/assert_macros.svh */
// Assertion helpers included by the top-level RTL file.
// Each check is sampled on the rising clock and switched off while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AST_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/pit_pkg.sv */
package pit_pkg;

    // Number of register stages from an accepted command to its result strobe.
    localparam int PIT_LATENCY = 4;

    // Result flags of one test.
    typedef struct packed {
        logic inside_res;
        logic degenerate;
    } t_pit_res;

endpackage

/* hw/rtl/pit_diff.sv */
module pit_diff
    import pit_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [COORD_WIDTH-1:0] i_ax,
    input  logic signed [COORD_WIDTH-1:0] i_ay,
    input  logic signed [COORD_WIDTH-1:0] i_bx,
    input  logic signed [COORD_WIDTH-1:0] i_by,
    input  logic signed [COORD_WIDTH-1:0] i_cx,
    input  logic signed [COORD_WIDTH-1:0] i_cy,
    input  logic signed [COORD_WIDTH-1:0] i_px,
    input  logic signed [COORD_WIDTH-1:0] i_py,
    output logic                          o_valid,
    output logic signed [COORD_WIDTH:0]   o_e0x,
    output logic signed [COORD_WIDTH:0]   o_e0y,
    output logic signed [COORD_WIDTH:0]   o_e1x,
    output logic signed [COORD_WIDTH:0]   o_e1y,
    output logic signed [COORD_WIDTH:0]   o_epx,
    output logic signed [COORD_WIDTH:0]   o_epy
);

    logic                        r_valid;
    logic signed [COORD_WIDTH:0] r_e0x, r_e0y, r_e1x, r_e1y, r_epx, r_epy;
    logic signed [COORD_WIDTH:0] n_e0x, n_e0y, n_e1x, n_e1y, n_epx, n_epy;

    // Edge vectors relative to vertex a, one bit wider so they are exact.
    always_comb begin
        n_e0x = {i_cx[COORD_WIDTH-1], i_cx} - {i_ax[COORD_WIDTH-1], i_ax};
        n_e0y = {i_cy[COORD_WIDTH-1], i_cy} - {i_ay[COORD_WIDTH-1], i_ay};
        n_e1x = {i_bx[COORD_WIDTH-1], i_bx} - {i_ax[COORD_WIDTH-1], i_ax};
        n_e1y = {i_by[COORD_WIDTH-1], i_by} - {i_ay[COORD_WIDTH-1], i_ay};
        n_epx = {i_px[COORD_WIDTH-1], i_px} - {i_ax[COORD_WIDTH-1], i_ax};
        n_epy = {i_py[COORD_WIDTH-1], i_py} - {i_ay[COORD_WIDTH-1], i_ay};
    end

    // Stage one valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Stage one payload.
    always_ff @(posedge i_clk) begin
        r_e0x <= n_e0x;
        r_e0y <= n_e0y;
        r_e1x <= n_e1x;
        r_e1y <= n_e1y;
        r_epx <= n_epx;
        r_epy <= n_epy;
    end

    assign o_valid = r_valid;
    assign o_e0x   = r_e0x;
    assign o_e0y   = r_e0y;
    assign o_e1x   = r_e1x;
    assign o_e1y   = r_e1y;
    assign o_epx   = r_epx;
    assign o_epy   = r_epy;

endmodule

/* hw/rtl/pit_cross.sv */
module pit_cross
    import pit_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic signed [COORD_WIDTH:0]     i_e0x,
    input  logic signed [COORD_WIDTH:0]     i_e0y,
    input  logic signed [COORD_WIDTH:0]     i_e1x,
    input  logic signed [COORD_WIDTH:0]     i_e1y,
    input  logic signed [COORD_WIDTH:0]     i_epx,
    input  logic signed [COORD_WIDTH:0]     i_epy,
    output logic                            o_valid,
    output logic signed [2*COORD_WIDTH+2:0] o_x,
    output logic signed [2*COORD_WIDTH+2:0] o_s,
    output logic signed [2*COORD_WIDTH+2:0] o_t
);

    localparam int PW = 2 * COORD_WIDTH + 2;
    localparam int CW = 2 * COORD_WIDTH + 3;

    logic                 r_valid_p;
    logic                 r_valid_c;
    logic signed [PW-1:0] r_x0, r_x1, r_s0, r_s1, r_t0, r_t1;
    logic signed [PW-1:0] n_x0, n_x1, n_s0, n_s1, n_t0, n_t1;
    logic signed [CW-1:0] r_x, r_s, r_t;
    logic signed [CW-1:0] n_x, n_s, n_t;

    // Partial products of the three cross products.
    always_comb begin
        n_x0 = PW'(i_e0x) * PW'(i_e1y);
        n_x1 = PW'(i_e0y) * PW'(i_e1x);
        n_s0 = PW'(i_epx) * PW'(i_e1y);
        n_s1 = PW'(i_epy) * PW'(i_e1x);
        n_t0 = PW'(i_e0x) * PW'(i_epy);
        n_t1 = PW'(i_e0y) * PW'(i_epx);
    end

    // Cross products from the registered partial products.
    always_comb begin
        n_x = {r_x0[PW-1], r_x0} - {r_x1[PW-1], r_x1};
        n_s = {r_s0[PW-1], r_s0} - {r_s1[PW-1], r_s1};
        n_t = {r_t0[PW-1], r_t0} - {r_t1[PW-1], r_t1};
    end

    // Valid bits of the product and difference stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_p <= 1'b0;
            r_valid_c <= 1'b0;
        end else begin
            r_valid_p <= i_valid;
            r_valid_c <= r_valid_p;
        end
    end

    // Payload of the product and difference stages.
    always_ff @(posedge i_clk) begin
        r_x0 <= n_x0;
        r_x1 <= n_x1;
        r_s0 <= n_s0;
        r_s1 <= n_s1;
        r_t0 <= n_t0;
        r_t1 <= n_t1;
        r_x  <= n_x;
        r_s  <= n_s;
        r_t  <= n_t;
    end

    assign o_valid = r_valid_c;
    assign o_x     = r_x;
    assign o_s     = r_s;
    assign o_t     = r_t;

endmodule

/* hw/rtl/pit_decide.sv */
module pit_decide
    import pit_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic signed [2*COORD_WIDTH+2:0] i_x,
    input  logic signed [2*COORD_WIDTH+2:0] i_s,
    input  logic signed [2*COORD_WIDTH+2:0] i_t,
    output logic                            o_valid,
    output t_pit_res                        o_res
);

    localparam int CW = 2 * COORD_WIDTH + 3;
    localparam int SW = CW + 1;

    logic                 r_valid;
    t_pit_res             r_res;
    t_pit_res             n_res;
    logic                 x_zero, x_pos, s_ok, t_ok, mag_ok;
    logic signed [SW-1:0] sum_st;
    logic signed [SW-1:0] x_ext;

    // Sign tests and the magnitude compare. With S and T both carrying the
    // sign of X, |S+T| < |X| reduces to a one-sided compare against X.
    always_comb begin
        x_zero = (i_x == '0);
        x_pos  = !i_x[CW-1];
        s_ok   = x_pos ? (!i_s[CW-1] && (i_s != '0)) : i_s[CW-1];
        t_ok   = x_pos ? (!i_t[CW-1] && (i_t != '0)) : i_t[CW-1];
        sum_st = {i_s[CW-1], i_s} + {i_t[CW-1], i_t};
        x_ext  = {i_x[CW-1], i_x};
        mag_ok = x_pos ? (sum_st < x_ext) : (sum_st > x_ext);
        n_res.degenerate = i_valid && x_zero;
        n_res.inside_res = i_valid && !x_zero && s_ok && t_ok && mag_ok;
    end

    // Result register; flags read zero when no result is presented.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_res   <= '0;
        end else begin
            r_valid <= i_valid;
            r_res   <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* hw/rtl/point_in_triangle_test_top.sv */
// Channel   Direction  Handshake                 Payload
// command   in         start, busy               i_vertex_{a,b,c}_{x,y}, i_query_{x,y}
// result    out        o_strobe (one cycle)      o_inside_res, o_degenerate
//
// One command is taken in every cycle; busy is never raised.
// Each result is registered in turn after its command: edge vectors, partial
// products, cross products, then the sign and magnitude decision.
// Reset is synchronous and active low; it clears the stage valid bits and the result flags.
// The result side cannot stall, so the pipeline never holds or drops an item.
module point_in_triangle_test_top
    import pit_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_a_x,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_a_y,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_b_x,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_b_y,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_c_x,
    input  logic signed [COORD_WIDTH-1:0] i_vertex_c_y,
    input  logic signed [COORD_WIDTH-1:0] i_query_x,
    input  logic signed [COORD_WIDTH-1:0] i_query_y,
    output logic                          o_strobe,
    output logic                          o_inside_res,
    output logic                          o_degenerate
);

`include "assert_macros.svh"

    logic                            accept;
    logic                            d_valid;
    logic signed [COORD_WIDTH:0]     e0x, e0y, e1x, e1y, epx, epy;
    logic                            c_valid;
    logic signed [2*COORD_WIDTH+2:0] cross_x, cross_s, cross_t;
    t_pit_res                        res;

    // Every cycle can take a transfer.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    pit_diff #(.COORD_WIDTH(COORD_WIDTH)) u_diff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_ax    (i_vertex_a_x),
        .i_ay    (i_vertex_a_y),
        .i_bx    (i_vertex_b_x),
        .i_by    (i_vertex_b_y),
        .i_cx    (i_vertex_c_x),
        .i_cy    (i_vertex_c_y),
        .i_px    (i_query_x),
        .i_py    (i_query_y),
        .o_valid (d_valid),
        .o_e0x   (e0x),
        .o_e0y   (e0y),
        .o_e1x   (e1x),
        .o_e1y   (e1y),
        .o_epx   (epx),
        .o_epy   (epy)
    );

    pit_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d_valid),
        .i_e0x   (e0x),
        .i_e0y   (e0y),
        .i_e1x   (e1x),
        .i_e1y   (e1y),
        .i_epx   (epx),
        .i_epy   (epy),
        .o_valid (c_valid),
        .o_x     (cross_x),
        .o_s     (cross_s),
        .o_t     (cross_t)
    );

    pit_decide #(.COORD_WIDTH(COORD_WIDTH)) u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_valid),
        .i_x     (cross_x),
        .i_s     (cross_s),
        .i_t     (cross_t),
        .o_valid (o_strobe),
        .o_res   (res)
    );

    assign o_inside_res = res.inside_res;
    assign o_degenerate = res.degenerate;

    // A degenerate triangle never reports an inside point.
    `AST_IMP(a_degen_not_inside, o_strobe, !(o_inside_res && o_degenerate))
    // Flags stay low between results.
    `AST_IMP(a_flags_idle, !o_strobe, !o_inside_res && !o_degenerate)
    // Each accepted command yields exactly one strobe after the pipeline depth.
    `AST_IMP(a_latency,
        $past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3) && $past(i_rst_n, 4),
        o_strobe == $past(accept, PIT_LATENCY))

endmodule
